// File: rtl/cascaded_biquad_highpass_unit_macros.svh
// Assertion macros shared by the cascaded biquad RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef CASCADED_BIQUAD_HIGHPASS_UNIT_MACROS_SVH
`define CASCADED_BIQUAD_HIGHPASS_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CBQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("cbq assertion failed");
`define CBQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("cbq assertion failed");
`else
`define CBQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CBQ_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/cbq_pkg.sv
// Package for the cascaded biquad filter: widths, register codes and control types.
// Used by every module of the block; depends on nothing.
`default_nettype none
package cbq_pkg;

	localparam int SAMPLE_WIDTH = 24;
	localparam int COEF_WIDTH   = 32;
	localparam int FRAC_BITS    = 28;

	// Sample digit width of the serial multiplier and the resulting digit count.
	localparam int DIGIT  = 8;
	localparam int NDIG   = (SAMPLE_WIDTH + DIGIT - 1) / DIGIT;
	localparam int DIG_CW = $clog2(NDIG);
	localparam int XW     = NDIG * DIGIT;
	localparam int PW     = COEF_WIDTH + XW;
	localparam int AW     = (PW + 3 > FRAC_BITS + SAMPLE_WIDTH + 1) ?
		PW + 3 : FRAC_BITS + SAMPLE_WIDTH + 1;
	localparam int SHW    = AW - FRAC_BITS;

	localparam int CFG_IDX_W = 3;

	// Register indexes; the same codes select the term being multiplied.
	localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

	localparam logic signed [COEF_WIDTH-1:0] COEF_B0_RST = COEF_WIDTH'(64'd1 << FRAC_BITS);

	typedef struct packed {
		logic clear;
		logic add;
		logic sub;
	} acc_ctl_t;

endpackage
`default_nettype wire

// File: rtl/cbq_digit_mul.sv
// Digit-serial signed multiplier: coefficient times sample, one sample digit per cycle while go or step is high.
// Most significant digit first; depends on cbq_pkg.
`default_nettype none
module cbq_digit_mul import cbq_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          go,
	input  wire logic                          step,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
	input  wire logic signed [COEF_WIDTH-1:0]  coef,
	output logic signed [PW-1:0]               prod
);

	logic signed [XW-1:0]           x_ext;
	logic        [XW-1:0]           x_q;
	logic        [DIGIT-1:0]        digit;
	logic signed [DIGIT:0]          digit_s;
	logic signed [COEF_WIDTH+DIGIT:0] partial;
	logic signed [PW-1:0]           prod_q;

	assign x_ext   = XW'(sample);
	assign digit   = go ? x_ext[XW-1 -: DIGIT] : x_q[XW-1 -: DIGIT];
	// The leading digit carries the sign; the rest are unsigned.
	assign digit_s = go ? {digit[DIGIT-1], digit} : {1'b0, digit};
	assign partial = coef * digit_s;

	always_ff @(posedge clk) begin
		if (go) begin
			x_q    <= x_ext << DIGIT;
			prod_q <= PW'(partial);
		end else if (step) begin
			x_q    <= x_q << DIGIT;
			prod_q <= (prod_q <<< DIGIT) + PW'(partial);
		end
	end

	assign prod = prod_q;

endmodule
`default_nettype wire

// File: rtl/cbq_acc.sv
// Full-width accumulator with rounding and saturation to the sample width.
// Takes products from cbq_digit_mul; depends on cbq_pkg.
`default_nettype none
module cbq_acc import cbq_pkg::*; (
	input  wire logic                           clk,
	input  wire acc_ctl_t                       ctl,
	input  wire logic signed [PW-1:0]           prod,
	output logic signed [SAMPLE_WIDTH-1:0]      y
);

	localparam logic signed [SHW-1:0] Y_MAX = SHW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [SHW-1:0] Y_MIN = SHW'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

	logic signed [AW-1:0]  acc_q;
	logic signed [SHW-1:0] shifted;

	// Clearing preloads the rounding half so the final shift rounds up at ties.
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= AW'(64'd1 << (FRAC_BITS - 1));
		end else if (ctl.add) begin
			acc_q <= acc_q + AW'(prod);
		end else if (ctl.sub) begin
			acc_q <= acc_q - AW'(prod);
		end
	end

	assign shifted = acc_q[AW-1:FRAC_BITS];

	always_comb begin
		if (shifted > Y_MAX) begin
			y = Y_MAX[SAMPLE_WIDTH-1:0];
		end else if (shifted < Y_MIN) begin
			y = Y_MIN[SAMPLE_WIDTH-1:0];
		end else begin
			y = shifted[SAMPLE_WIDTH-1:0];
		end
	end

endmodule
`default_nettype wire

// File: rtl/cascaded_biquad_highpass_unit.sv
// An accepted item runs through section 0 and then section 1; in_ready stays low until
// its result is written, and that write waits while an earlier result is not yet taken.
// The single digit-serial multiplier serves all ten products, NDIG digits each.
// Reset (arst_n low) clears the state machine, the delay lines and the output valid,
// and loads the coefficients with b0 = 1.0 and the others zero.
`default_nettype none
`include "cascaded_biquad_highpass_unit_macros.svh"
module cascaded_biquad_highpass_unit import cbq_pkg::*; (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [CFG_IDX_W-1:0]           cfg_index,
	input  wire logic [COEF_WIDTH-1:0]          cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]      sample_out
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FIRST = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_ACC   = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	localparam logic [DIG_CW-1:0] DIG_LAST = DIG_CW'(NDIG - 1);

	logic [2:0]                    state_q;
	logic                          sec_q;
	logic [CFG_IDX_W-1:0]          term_q;
	logic [DIG_CW-1:0]             dig_q;
	logic signed [COEF_WIDTH-1:0]  coef_q [5];
	logic signed [SAMPLE_WIDTH-1:0] xd_q [2][2];
	logic signed [SAMPLE_WIDTH-1:0] yd_q [2][2];
	logic signed [SAMPLE_WIDTH-1:0] sec_x_q;
	logic signed [SAMPLE_WIDTH-1:0] out_data_q;
	logic                          out_valid_q;

	logic signed [SAMPLE_WIDTH-1:0] operand;
	logic signed [COEF_WIDTH-1:0]  coef_sel;
	logic signed [PW-1:0]          prod;
	logic signed [SAMPLE_WIDTH-1:0] y;
	acc_ctl_t                      acc_ctl;
	logic                          in_fire;
	logic                          fin_fire;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign fin_fire = (state_q == S_FIN) && (!sec_q || !out_valid_q || out_ready);

	always_comb begin
		case (term_q)
			REG_B0: begin
				operand  = sec_x_q;
				coef_sel = coef_q[0];
			end
			REG_B1: begin
				operand  = xd_q[sec_q][0];
				coef_sel = coef_q[1];
			end
			REG_B2: begin
				operand  = xd_q[sec_q][1];
				coef_sel = coef_q[2];
			end
			REG_A1: begin
				operand  = yd_q[sec_q][0];
				coef_sel = coef_q[3];
			end
			default: begin
				operand  = yd_q[sec_q][1];
				coef_sel = coef_q[4];
			end
		endcase
	end

	always_comb begin
		acc_ctl.clear = in_fire || (fin_fire && !sec_q);
		acc_ctl.add   = (state_q == S_ACC) && (term_q == REG_B0 || term_q == REG_B1 ||
			term_q == REG_B2);
		acc_ctl.sub   = (state_q == S_ACC) && (term_q == REG_A1 || term_q == REG_A2);
	end

	cbq_digit_mul u_mul (
		.clk    (clk),
		.go     (state_q == S_FIRST),
		.step   (state_q == S_MUL),
		.sample (operand),
		.coef   (coef_sel),
		.prod   (prod)
	);

	cbq_acc u_acc (
		.clk  (clk),
		.ctl  (acc_ctl),
		.prod (prod),
		.y    (y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= COEF_B0_RST;
			coef_q[1] <= '0;
			coef_q[2] <= '0;
			coef_q[3] <= '0;
			coef_q[4] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_B0:  coef_q[0] <= cfg_data;
				REG_B1:  coef_q[1] <= cfg_data;
				REG_B2:  coef_q[2] <= cfg_data;
				REG_A1:  coef_q[3] <= cfg_data;
				REG_A2:  coef_q[4] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sec_q       <= 1'b0;
			term_q      <= REG_B0;
			dig_q       <= '0;
			out_valid_q <= 1'b0;
			xd_q        <= '{default: '0};
			yd_q        <= '{default: '0};
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						sec_q   <= 1'b0;
						term_q  <= REG_B0;
						state_q <= S_FIRST;
					end
				end
				S_FIRST: begin
					dig_q   <= DIG_CW'(1);
					state_q <= (DIG_LAST == '0) ? S_ACC : S_MUL;
				end
				S_MUL: begin
					if (dig_q == DIG_LAST) begin
						state_q <= S_ACC;
					end else begin
						dig_q <= dig_q + DIG_CW'(1);
					end
				end
				S_ACC: begin
					if (term_q == REG_A2) begin
						state_q <= S_FIN;
					end else begin
						term_q  <= term_q + CFG_IDX_W'(1);
						state_q <= S_FIRST;
					end
				end
				S_FIN: begin
					if (fin_fire) begin
						xd_q[sec_q][1] <= xd_q[sec_q][0];
						xd_q[sec_q][0] <= sec_x_q;
						yd_q[sec_q][1] <= yd_q[sec_q][0];
						yd_q[sec_q][0] <= y;
						term_q         <= REG_B0;
						if (sec_q) begin
							out_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end else begin
							sec_q   <= 1'b1;
							state_q <= S_FIRST;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sec_x_q <= sample_in;
		end else if (fin_fire && !sec_q) begin
			sec_x_q <= y;
		end
		if (fin_fire && sec_q) begin
			out_data_q <= y;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_data_q;

	`CBQ_ASSERT_NXT(a_accept_starts, clk, arst_n, in_fire,
		state_q == S_FIRST && !sec_q && term_q == REG_B0)
	`CBQ_ASSERT_IMP(a_acc_after_digits, clk, arst_n, state_q == S_ACC, dig_q == DIG_LAST)
	`CBQ_ASSERT_IMP(a_result_from_second, clk, arst_n, $rose(out_valid_q),
		$past(state_q) == S_FIN && $past(sec_q))
	`CBQ_ASSERT_IMP(a_term_range, clk, arst_n, state_q != S_IDLE, term_q <= REG_A2)

endmodule
`default_nettype wire

// File: test/tb_cascaded_biquad_highpass_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for cascaded_biquad_highpass_unit: directed table, then random phases.
// Outputs are compared to a two-section biquad predictor, or to the table value for known rows.
// Depends on cbq_pkg and the RTL of the block only.
module tb_cascaded_biquad_highpass_unit import cbq_pkg::*;;

	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 10;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 100;
	localparam int HOLD_CYCLES = 400;
	localparam int N_PHASES = 10;
	localparam int ITEMS_PER_PHASE = 75;
	localparam int N_COEFS = 5;
	localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
	localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE0 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE1 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 3'd7;

	typedef enum logic [1:0] {ROW_COEF, ROW_SAMPLE, ROW_KNOWN} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [31:0]            value;
		logic [SAMPLE_WIDTH-1:0] want;
	} row_t;

	localparam int N_DIRECTED = 40;
	localparam row_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{ROW_KNOWN,  REG_B0,     32'h0000_0000, 24'h000000},
		'{ROW_KNOWN,  REG_B0,     32'h007F_FFFF, 24'h7FFFFF},
		'{ROW_KNOWN,  REG_B0,     32'h0080_0000, 24'h800000},
		'{ROW_KNOWN,  REG_B0,     32'h0000_0001, 24'h000001},
		'{ROW_KNOWN,  REG_B0,     32'h00FF_FFFF, 24'hFFFFFF},
		'{ROW_KNOWN,  REG_B0,     32'h0055_5555, 24'h555555},
		'{ROW_KNOWN,  REG_B0,     32'h00AA_AAAA, 24'hAAAAAA},
		'{ROW_COEF,   REG_B0,     32'h0800_0000, 24'h000000},
		'{ROW_KNOWN,  REG_B0,     32'h0000_0001, 24'h000001},
		'{ROW_KNOWN,  REG_B0,     32'h00FF_FFFF, 24'h000000},
		'{ROW_KNOWN,  REG_B0,     32'h0000_0003, 24'h000001},
		'{ROW_KNOWN,  REG_B0,     32'h00FF_FFFD, 24'h000000},
		'{ROW_COEF,   REG_B0,     32'h8000_0000, 24'h000000},
		'{ROW_KNOWN,  REG_B0,     32'h007F_FFFF, 24'h7FFFFF},
		'{ROW_KNOWN,  REG_B0,     32'h0080_0000, 24'h800000},
		'{ROW_COEF,   REG_B0,     32'h7FFF_FFFF, 24'h000000},
		'{ROW_KNOWN,  REG_B0,     32'h007F_FFFF, 24'h7FFFFF},
		'{ROW_KNOWN,  REG_B0,     32'h0080_0000, 24'h800000},
		'{ROW_COEF,   REG_B0,     32'h0000_0000, 24'h000000},
		'{ROW_KNOWN,  REG_B0,     32'h007F_FFFF, 24'h000000},
		'{ROW_COEF,   REG_B0,     32'h0F00_0000, 24'h000000},
		'{ROW_COEF,   REG_B1,     32'hE200_0000, 24'h000000},
		'{ROW_COEF,   REG_B2,     32'h0F00_0000, 24'h000000},
		'{ROW_COEF,   REG_A1,     32'hE200_0000, 24'h000000},
		'{ROW_COEF,   REG_A2,     32'h0E14_7AE1, 24'h000000},
		'{ROW_SAMPLE, REG_B0,     32'h007F_FFFF, 24'h000000},
		'{ROW_SAMPLE, REG_B0,     32'h007F_FFFF, 24'h000000},
		'{ROW_SAMPLE, REG_B0,     32'h0080_0000, 24'h000000},
		'{ROW_SAMPLE, REG_B0,     32'h0000_0000, 24'h000000},
		'{ROW_SAMPLE, REG_B0,     32'h0000_0400, 24'h000000},
		'{ROW_COEF,   REG_A1,     32'h8000_0000, 24'h000000},
		'{ROW_COEF,   REG_A2,     32'h7FFF_FFFF, 24'h000000},
		'{ROW_SAMPLE, REG_B0,     32'h0000_0001, 24'h000000},
		'{ROW_SAMPLE, REG_B0,     32'h007F_FFFF, 24'h000000},
		'{ROW_SAMPLE, REG_B0,     32'h0000_0000, 24'h000000},
		'{ROW_SAMPLE, REG_B0,     32'h0080_0000, 24'h000000},
		'{ROW_COEF,   REG_SPARE0, 32'hDEAD_BEEF, 24'h000000},
		'{ROW_COEF,   REG_SPARE1, 32'hFFFF_FFFF, 24'h000000},
		'{ROW_COEF,   REG_SPARE2, 32'h0000_0000, 24'h000000},
		'{ROW_SAMPLE, REG_B0,     32'h0012_3456, 24'h000000}
	};

	localparam logic [COEF_WIDTH-1:0] COEF_EXTREMES [5] = '{
		32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h1000_0000, 32'hF000_0000
	};
	localparam logic [SAMPLE_WIDTH-1:0] PEAK_SAMPLES [5] = '{
		24'h7FFFFF, 24'h800000, 24'h000000, 24'h000001, 24'hFFFFFF
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COEF_WIDTH-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;
	logic out_valid;
	logic out_ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;

	logic signed [COEF_WIDTH-1:0] coef_q28 [N_COEFS];
	logic signed [SAMPLE_WIDTH-1:0] sec_in_hist [2][2];
	logic signed [SAMPLE_WIDTH-1:0] sec_out_hist [2][2];
	logic signed [SAMPLE_WIDTH-1:0] expected_samples [$];
	logic signed [SAMPLE_WIDTH-1:0] last_sample;

	int fail_count;
	int burst_left;
	int hold_off_requests;

	cascaded_biquad_highpass_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic signed [SAMPLE_WIDTH-1:0] biquad_section(input int sec,
			input logic signed [SAMPLE_WIDTH-1:0] x);
		longint acc;
		longint rounded;
		logic signed [SAMPLE_WIDTH-1:0] y;
		acc = longint'(coef_q28[REG_B0]) * longint'(x)
			+ longint'(coef_q28[REG_B1]) * longint'(sec_in_hist[sec][0])
			+ longint'(coef_q28[REG_B2]) * longint'(sec_in_hist[sec][1])
			- longint'(coef_q28[REG_A1]) * longint'(sec_out_hist[sec][0])
			- longint'(coef_q28[REG_A2]) * longint'(sec_out_hist[sec][1])
			+ (longint'(1) << (FRAC_BITS - 1));
		rounded = acc >>> FRAC_BITS;
		if (rounded > SAMPLE_MAX) begin
			y = SAMPLE_MAX[SAMPLE_WIDTH-1:0];
		end else if (rounded < SAMPLE_MIN) begin
			y = SAMPLE_MIN[SAMPLE_WIDTH-1:0];
		end else begin
			y = rounded[SAMPLE_WIDTH-1:0];
		end
		sec_in_hist[sec][1] = sec_in_hist[sec][0];
		sec_in_hist[sec][0] = x;
		sec_out_hist[sec][1] = sec_out_hist[sec][0];
		sec_out_hist[sec][0] = y;
		return y;
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] cascade_filter(
			input logic signed [SAMPLE_WIDTH-1:0] x);
		return biquad_section(1, biquad_section(0, x));
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 5) begin
			last_sample = SAMPLE_WIDTH'($urandom);
		end else if (pick < 7) begin
			last_sample = SAMPLE_WIDTH'($urandom_range(0, 2000) - 1000);
		end else if (pick < 8) begin
			last_sample = PEAK_SAMPLES[$urandom_range(0, 4)];
		end
		return last_sample;
	endfunction

	task automatic sender_pause();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 60)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 12);
		end
	endtask

	task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] x, input bit known,
			input logic signed [SAMPLE_WIDTH-1:0] want);
		logic signed [SAMPLE_WIDTH-1:0] y;
		in_valid <= 1'b1;
		sample_in <= x;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		y = cascade_filter(x);
		expected_samples.push_back(known ? want : y);
		sender_pause();
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_samples.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_WIDTH-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx <= REG_A2) coef_q28[idx] = val;
	endtask

	// Receiver: checks every accepted result and stalls on its own changing pattern.
	initial begin
		int stall_pct;
		int pattern_left;
		int hold_left;
		int hold_served;
		logic signed [SAMPLE_WIDTH-1:0] want;
		stall_pct = 0;
		pattern_left = 0;
		hold_left = 0;
		hold_served = 0;
		fail_count = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (expected_samples.size() == 0) begin
					$error("sample_out: expected none, actual %0d", sample_out);
					fail_count++;
				end else begin
					want = expected_samples.pop_front();
					if (sample_out !== want) begin
						$error("sample_out: expected %0d, actual %0d", want, sample_out);
						fail_count++;
					end
				end
			end
			if (hold_served != hold_off_requests) begin
				hold_served = hold_off_requests;
				hold_left = HOLD_CYCLES;
			end
			if (pattern_left == 0) begin
				pattern_left = $urandom_range(20, 300);
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 25;
					2: stall_pct = 60;
					default: stall_pct = 90;
				endcase
			end else begin
				pattern_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int i;
		int r;
		int phase;
		int k;
		int kind;
		int g;
		int a1v;
		int a2v;
		logic [COEF_WIDTH-1:0] next_coefs [N_COEFS];
		bit writing;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_B0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		sample_in <= '0;
		burst_left = 0;
		hold_off_requests = 0;
		last_sample = '0;
		writing = 1'b0;
		coef_q28[REG_B0] = COEF_B0_RST;
		coef_q28[REG_B1] = '0;
		coef_q28[REG_B2] = '0;
		coef_q28[REG_A1] = '0;
		coef_q28[REG_A2] = '0;
		for (i = 0; i < 2; i++) begin
			sec_in_hist[i] = '{default: '0};
			sec_out_hist[i] = '{default: '0};
		end
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (i = 0; i < N_DIRECTED; i++) begin
			if (DIRECTED_ROWS[i].kind == ROW_COEF) begin
				if (!writing) wait_idle();
				writing = 1'b1;
				put_coef(DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].value);
			end else begin
				if (writing) begin
					cfg_we <= 1'b0;
					writing = 1'b0;
				end
				send_sample(DIRECTED_ROWS[i].value[SAMPLE_WIDTH-1:0],
					DIRECTED_ROWS[i].kind == ROW_KNOWN, DIRECTED_ROWS[i].want);
			end
		end

		for (phase = 0; phase < N_PHASES; phase++) begin
			kind = (phase < 4) ? phase : $urandom_range(0, 3);
			case (kind)
				0: begin
					for (r = 0; r < N_COEFS; r++) next_coefs[r] = $urandom;
				end
				1: begin
					// Stable second-order high-pass shape with random detuning.
					g = 32'h1000_0000 - $urandom_range(0, 1 << 24);
					a2v = 32'h1000_0000 - $urandom_range(1 << 22, 1 << 25);
					a1v = -(a2v + 32'h1000_0000) + $urandom_range(1 << 20, 1 << 24);
					next_coefs[REG_B0] = g;
					next_coefs[REG_B1] = -2 * g;
					next_coefs[REG_B2] = g;
					next_coefs[REG_A1] = a1v;
					next_coefs[REG_A2] = a2v;
				end
				2: begin
					for (r = 0; r < N_COEFS; r++)
						next_coefs[r] = COEF_EXTREMES[$urandom_range(0, 4)];
				end
				default: begin
					for (r = 0; r < N_COEFS; r++)
						next_coefs[r] = $urandom_range(0, 1 << 29) - (1 << 28);
				end
			endcase
			wait_idle();
			for (r = 0; r < N_COEFS; r++) put_coef(CFG_IDX_W'(r), next_coefs[r]);
			put_coef(REG_SPARE0 + CFG_IDX_W'($urandom_range(0, 2)), $urandom);
			cfg_we <= 1'b0;
			if (phase == 2 || phase == 6) hold_off_requests++;
			for (k = 0; k < ITEMS_PER_PHASE; k++) send_sample(random_sample(), 1'b0, '0);
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_samples.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
